// ===== rtl/obj_vertex_text_parser_assert.svh =====
// Assertion macros shared by the checker
`ifndef OBJ_VERTEX_TEXT_PARSER_ASSERT_SVH
`define OBJ_VERTEX_TEXT_PARSER_ASSERT_SVH
// Assert a property on the rising clock, disabled in reset
`define OVP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert a property that must also hold during reset
`define OVP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/ovp_pkg.sv =====
package ovp_pkg;
    localparam logic [7:0] C_ZERO    = 8'd48;
    localparam logic [7:0] C_NEWLINE = 8'd10;
    localparam logic [7:0] C_LOW_V   = 8'h76;
    localparam logic [7:0] C_UP_V    = 8'h56;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_MINUS   = 8'h2d;
    localparam logic [7:0] C_POINT   = 8'h2e;
    localparam int         C_MAX_FRAC_DIGITS = 9;

    typedef enum logic { KIND_COMPONENT = 1'b0, KIND_SUMMARY = 1'b1 } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic         kind;
        logic [23:0]  vertex_index;
        logic [1:0]   component_index;
        logic signed [31:0] value;
        logic [23:0]  vertex_count;
        logic         loaded_ok;
        logic         last;
    } t_out_item;

    // Work request from the front part to the converter
    typedef struct packed {
        logic        is_summary;
        logic        has_comp;
        logic        last_comp;
        logic [23:0] vertex_index;
        logic [1:0]  component_index;
        logic        neg;
        logic [31:0] ipart;
        logic [31:0] fpart;
        logic [3:0]  ndig;
        logic [23:0] vertex_count;
        logic        loaded_ok;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_SUM, ST_OUT_C, ST_OUT_S
    } t_cvt_state;

    function automatic logic [29:0] pow10(input logic [3:0] n);
        unique case (n)
            4'd0: pow10 = 30'd1;
            4'd1: pow10 = 30'd10;
            4'd2: pow10 = 30'd100;
            4'd3: pow10 = 30'd1000;
            4'd4: pow10 = 30'd10000;
            4'd5: pow10 = 30'd100000;
            4'd6: pow10 = 30'd1000000;
            4'd7: pow10 = 30'd10000000;
            4'd8: pow10 = 30'd100000000;
            default: pow10 = 30'd1000000000;
        endcase
    endfunction
endpackage

// ===== rtl/ovp_front.sv =====
// Line scanner: classifies bytes and accumulates one component
module ovp_front #(
    parameter int VERTEX_INDEX_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ovp_pkg::t_in_item i_item,
    input  logic              i_valid,
    output logic              o_ready,
    output ovp_pkg::t_job     o_job,
    output logic              o_job_valid,
    input  logic              i_job_full
);
    import ovp_pkg::*;

    localparam logic [VERTEX_INDEX_BITS-1:0] CMAX = '1;

    logic [1:0]  r_pos;
    logic        r_first_v, r_in_v, r_started, r_point, r_neg;
    logic [31:0] r_iacc, r_facc;
    logic [3:0]  r_fdig;
    logic [1:0]  r_next;
    logic [VERTEX_INDEX_BITS-1:0] r_cnt;
    // second job of an end-of-file byte waiting for queue space
    logic        r_hold;
    t_job        r_hold_job;

    logic [7:0]  b;
    logic        eof, acc, fin;
    logic [31:0] d;
    logic [VERTEX_INDEX_BITS-1:0] n_cnt, idx;
    t_job        comp_job, sum_job;

    assign b   = i_item.text_byte;
    assign eof = i_item.end_of_file;
    assign d   = {24'd0, b} - {24'd0, C_ZERO};
    assign o_ready = !r_hold && !i_job_full;
    assign acc = i_valid && o_ready;

    // count update on the second byte of a vertex line
    always_comb begin
        n_cnt = r_cnt;
        if (b != C_NEWLINE && r_pos == 2'd1 && r_first_v && b == C_SPACE && r_cnt != CMAX)
            n_cnt = r_cnt + 1'b1;
    end
    assign idx = (n_cnt != '0) ? n_cnt - 1'b1 : '0;

    // a component of a vertex line finishes on newline, on a space, or at end of file
    always_comb begin
        fin = 1'b0;
        if (b == C_NEWLINE) fin = r_in_v;
        else if (r_pos == 2'd2 && r_in_v && b == C_SPACE) fin = 1'b1;
        if (eof && r_in_v) fin = 1'b1;
    end

    logic        c_started, c_point, c_neg;
    logic [31:0] c_iacc, c_facc;
    logic [3:0]  c_fdig;
    // accumulate the current byte before an end-of-file finish
    always_comb begin
        c_started = r_started; c_point = r_point; c_neg = r_neg;
        c_iacc = r_iacc; c_facc = r_facc; c_fdig = r_fdig;
        if (b != C_NEWLINE && r_pos == 2'd2 && r_in_v && b != C_SPACE) begin
            c_started = 1'b1;
            if (b == C_MINUS) c_neg = 1'b1;
            else if (b == C_POINT) c_point = 1'b1;
            else if (r_point) begin
                if (r_fdig < 4'(C_MAX_FRAC_DIGITS)) begin
                    c_facc = r_facc * 32'd10 + d;
                    c_fdig = r_fdig + 1'b1;
                end
            end else c_iacc = r_iacc * 32'd10 + d;
        end
    end

    always_comb begin
        comp_job = '0;
        comp_job.has_comp = fin && c_started && r_next != 2'd3;
        comp_job.last_comp = !eof;
        comp_job.vertex_index = 24'(idx);
        comp_job.component_index = r_next;
        comp_job.neg = c_neg;
        comp_job.ipart = c_iacc;
        comp_job.fpart = c_facc;
        comp_job.ndig = c_fdig;
        sum_job = '0;
        sum_job.is_summary = 1'b1;
        sum_job.vertex_count = 24'(n_cnt);
        sum_job.loaded_ok = n_cnt != '0;
    end

    // push at most one job a cycle; a summary after a component waits in the hold register until the queue has room
    always_comb begin
        o_job = comp_job;
        o_job_valid = 1'b0;
        if (r_hold) begin
            o_job = r_hold_job; o_job_valid = 1'b1;
        end else if (acc) begin
            if (comp_job.has_comp) begin
                o_job = comp_job; o_job_valid = 1'b1;
            end else if (eof) begin
                o_job = sum_job; o_job_valid = 1'b1;
            end
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_first_v <= 1'b0; r_in_v <= 1'b0; r_started <= 1'b0;
            r_point <= 1'b0; r_neg <= 1'b0; r_iacc <= '0; r_facc <= '0;
            r_fdig <= '0; r_next <= '0; r_cnt <= '0; r_hold <= 1'b0;
        end else begin
            if (r_hold && !i_job_full) r_hold <= 1'b0;
            if (acc) begin
                r_cnt <= n_cnt;
                if (eof && comp_job.has_comp) begin
                    r_hold <= 1'b1;
                    r_hold_job <= sum_job;
                end
                if (b == C_NEWLINE || eof) begin
                    r_pos <= '0; r_first_v <= 1'b0; r_in_v <= 1'b0; r_next <= '0;
                    r_started <= 1'b0; r_point <= 1'b0; r_neg <= 1'b0;
                    r_iacc <= '0; r_facc <= '0; r_fdig <= '0;
                end else if (r_pos == 2'd0) begin
                    r_first_v <= (b == C_LOW_V || b == C_UP_V);
                    r_pos <= 2'd1;
                end else if (r_pos == 2'd1) begin
                    if (r_first_v && b == C_SPACE) r_in_v <= 1'b1;
                    r_pos <= 2'd2;
                end else if (fin) begin
                    if (c_started && r_next != 2'd3) r_next <= r_next + 1'b1;
                    r_started <= 1'b0; r_point <= 1'b0; r_neg <= 1'b0;
                    r_iacc <= '0; r_facc <= '0; r_fdig <= '0;
                end else begin
                    r_started <= c_started; r_point <= c_point; r_neg <= c_neg;
                    r_iacc <= c_iacc; r_facc <= c_facc; r_fdig <= c_fdig;
                end
            end
        end
    end
endmodule

// ===== rtl/ovp_queue.sv =====
// Two-entry job queue between scanner and converter
module ovp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ovp_pkg::t_job i_job,
    input  logic          i_push,
    output logic          o_full,
    output ovp_pkg::t_job o_job,
    output logic          o_empty,
    input  logic          i_pop
);
    import ovp_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_job;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= !r_wp;
            if (i_pop && !o_empty) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end
endmodule

// ===== rtl/ovp_convert.sv =====
// Fixed-point converter: scale, divide by 10^n bit-serially, add and saturate; summaries pass through
module ovp_convert #(
    parameter int FRACTION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ovp_pkg::t_job    i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output ovp_pkg::t_out_item o_item,
    output logic             o_empty,
    input  logic             i_pop
);
    import ovp_pkg::*;

    localparam int NW = 32 + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    t_cvt_state r_st, n_st;
    t_job       r_job;
    logic [NW-1:0] r_num;       // dividend, shifts out into quotient
    logic [30:0]   r_rem;
    logic [29:0]   r_div;
    logic [CW-1:0] r_bit;
    logic signed [63:0] r_ipart_s;
    t_out_item     r_out;
    logic          r_out_v;

    logic [31:0] mag;
    logic [30:0] rem_sh;
    logic signed [63:0] total, frac;

    assign mag = r_job.fpart[31] ? (~r_job.fpart + 1'b1) : r_job.fpart;
    assign rem_sh = {r_rem[29:0], r_num[NW-1]};
    assign frac = r_job.fpart[31] ? -$signed({16'd0, r_num}) : $signed({16'd0, r_num});
    assign total = r_job.neg ? -(r_ipart_s + frac) : (r_ipart_s + frac);

    assign o_pop   = r_st == ST_IDLE && !i_empty;
    assign o_item  = r_out;
    assign o_empty = !r_out_v;

    // sequencer
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (!i_empty) n_st = i_job.is_summary ? ST_OUT_S : ST_MUL;
            ST_MUL:   n_st = ST_DIV;
            ST_DIV:   if (r_bit == CW'(NW - 1)) n_st = ST_SUM;
            ST_SUM:   n_st = ST_OUT_C;
            ST_OUT_C: if (!r_out_v || i_pop) n_st = ST_IDLE;
            ST_OUT_S: if (!r_out_v || i_pop) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_out_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_pop && r_out_v) r_out_v <= 1'b0;
            if ((r_st == ST_OUT_C || r_st == ST_OUT_S) && (!r_out_v || i_pop))
                r_out_v <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: if (!i_empty) r_job <= i_job;
            ST_MUL: begin
                // (mag << F) + p/2, then restoring division by p
                r_div <= pow10(r_job.ndig);
                r_num <= (NW'(mag) << FRACTION_BITS) + NW'(pow10(r_job.ndig) >> 1);
                r_rem <= '0;
                r_bit <= '0;
                r_ipart_s <= $signed({{32{r_job.ipart[31]}}, r_job.ipart}) <<< FRACTION_BITS;
            end
            ST_DIV: begin
                r_bit <= r_bit + 1'b1;
                if (rem_sh >= {1'b0, r_div}) begin
                    r_rem <= rem_sh - {1'b0, r_div};
                    r_num <= {r_num[NW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_num <= {r_num[NW-2:0], 1'b0};
                end
            end
            ST_SUM: begin
                r_ipart_s <= total;
            end
            ST_OUT_C: if (!r_out_v || i_pop) begin
                r_out.kind <= KIND_COMPONENT;
                r_out.vertex_index <= r_job.vertex_index;
                r_out.component_index <= r_job.component_index;
                if (r_ipart_s > 64'sd2147483647) r_out.value <= 32'h7fffffff;
                else if (r_ipart_s < -64'sd2147483648) r_out.value <= 32'h80000000;
                else r_out.value <= r_ipart_s[31:0];
                r_out.vertex_count <= '0;
                r_out.loaded_ok <= 1'b0;
                r_out.last <= r_job.last_comp;
            end
            ST_OUT_S: if (!r_out_v || i_pop) begin
                r_out.kind <= KIND_SUMMARY;
                r_out.vertex_index <= '0;
                r_out.component_index <= '0;
                r_out.value <= '0;
                r_out.vertex_count <= r_job.vertex_count;
                r_out.loaded_ok <= r_job.loaded_ok;
                r_out.last <= 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/obj_vertex_text_parser.sv =====
// Vertex text parser. Bytes are taken one per cycle while the scanner's job
// queue has room and no summary job is held; each component goes through the
// converter (setup, a bit-serial divide by 10^n over 32 + FRACTION_BITS steps,
// sum and output), so the converter sets the rate: once the two-entry job queue
// is full the input stalls. End of file yields one more summary result after
// any final component.
module obj_vertex_text_parser #(
    parameter int FRACTION_BITS = 16,
    parameter int VERTEX_INDEX_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ovp_pkg::t_in_item   i_item,
    input  logic                push,
    output logic                full,
    output ovp_pkg::t_out_item  o_item,
    output logic                empty,
    input  logic                pop
);
    import ovp_pkg::*;

    t_job q_in, q_out;
    logic q_push, q_full, q_empty, q_pop, rdy;

    assign full = !rdy;

    ovp_front #(.VERTEX_INDEX_BITS(VERTEX_INDEX_BITS)) u_front (
        .i_clk, .i_rst_n, .i_item, .i_valid(push), .o_ready(rdy),
        .o_job(q_in), .o_job_valid(q_push), .i_job_full(q_full)
    );

    ovp_queue u_queue (
        .i_clk, .i_rst_n, .i_job(q_in), .i_push(q_push), .o_full(q_full),
        .o_job(q_out), .o_empty(q_empty), .i_pop(q_pop)
    );

    ovp_convert #(.FRACTION_BITS(FRACTION_BITS)) u_cvt (
        .i_clk, .i_rst_n, .i_job(q_out), .i_empty(q_empty), .o_pop(q_pop),
        .o_item, .o_empty(empty), .i_pop(pop)
    );
endmodule

// ===== rtl/ovp_checker.sv =====
`include "obj_vertex_text_parser_assert.svh"
// Port-level checks
module ovp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input ovp_pkg::t_out_item o_item
);
    import ovp_pkg::*;
    `OVP_ASSERT(a_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_item), "result changed while waiting")
    `OVP_ASSERT(a_sum_last, i_clk, i_rst_n, !empty && o_item.kind == KIND_SUMMARY |-> o_item.last, "summary not last")
    `OVP_ASSERT(a_ok, i_clk, i_rst_n, !empty && o_item.kind == KIND_SUMMARY |-> o_item.loaded_ok == (o_item.vertex_count != 0), "loaded flag mismatch")
    `OVP_ASSERT(a_cidx, i_clk, i_rst_n, !empty && o_item.kind == KIND_COMPONENT |-> o_item.component_index != 2'd3, "bad component index")
    `OVP_ASSERT_ALWAYS(a_rst, i_clk, !$past(i_rst_n) && i_rst_n |-> empty, "result after reset")
endmodule

bind obj_vertex_text_parser ovp_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .o_item
);

// ===== verif/tb_obj_vertex_text_parser.sv =====
module tb_obj_vertex_text_parser;
    import ovp_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_BYTES   = 160;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    t_in_item  i_item = '0;
    logic      push = 1'b0;
    logic      full;
    t_out_item o_item;
    logic      empty;
    logic      pop = 1'b0;

    obj_vertex_text_parser DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_item),
        .push   (push),
        .full   (full),
        .o_item (o_item),
        .empty  (empty),
        .pop    (pop)
    );

    always #10 i_clk = ~i_clk;

    // Pending requests and expected results
    t_in_item  byte_q[$];
    t_out_item result_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int cycles = 0;
    logic hold_req = 1'b0;

    // Parser state mirror
    logic [1:0]  pos_in_line = '0;
    logic        first_v = 1'b0;
    logic        vline = 1'b0;
    logic        started = 1'b0;
    logic        point = 1'b0;
    logic        minus = 1'b0;
    logic [31:0] int_acc = '0;
    logic [31:0] frac_acc = '0;
    logic [3:0]  frac_cnt = '0;
    logic [1:0]  comp_no = '0;
    logic [23:0] vcount = '0;

    t_out_item step_out[$];

    function automatic logic [31:0] fixed_value();
        longint ip, fp, p, mag, r, fr, total;
        ip = longint'($signed(int_acc));
        fp = longint'($signed(frac_acc));
        p = 1;
        repeat ((frac_cnt > 9) ? 9 : frac_cnt) p = p * 10;
        mag = (fp < 0) ? -fp : fp;
        r = ((mag << FRAC_BITS) + p / 2) / p;
        fr = (fp < 0) ? -r : r;
        total = ip * (longint'(1) << FRAC_BITS) + fr;
        if (minus) total = -total;
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        return total[31:0];
    endfunction

    function automatic void clear_comp();
        started = 1'b0;
        point = 1'b0;
        minus = 1'b0;
        int_acc = '0;
        frac_acc = '0;
        frac_cnt = '0;
    endfunction

    function automatic void clear_line();
        pos_in_line = '0;
        first_v = 1'b0;
        vline = 1'b0;
        comp_no = '0;
        clear_comp();
    endfunction

    function automatic void close_comp();
        t_out_item r;
        if (started && comp_no < 2'd3) begin
            r = '0;
            r.kind = KIND_COMPONENT;
            r.vertex_index = (vcount != 0) ? vcount - 24'd1 : 24'd0;
            r.component_index = comp_no;
            r.value = fixed_value();
            step_out.push_back(r);
            comp_no = comp_no + 2'd1;
        end
        clear_comp();
    endfunction

    function automatic void take_char(logic [7:0] b);
        started = 1'b1;
        if (b == C_MINUS) minus = 1'b1;
        else if (b == C_POINT) point = 1'b1;
        else if (point) begin
            if (frac_cnt < C_MAX_FRAC_DIGITS) begin
                frac_acc = frac_acc * 32'd10 + (32'(b) - 32'(C_ZERO));
                frac_cnt = frac_cnt + 4'd1;
            end
        end else begin
            int_acc = int_acc * 32'd10 + (32'(b) - 32'(C_ZERO));
        end
    endfunction

    // Expected results for one accepted byte
    function automatic void predict_byte(t_in_item it);
        t_out_item s;
        step_out.delete();
        if (it.text_byte == C_NEWLINE) begin
            if (vline) close_comp();
            clear_line();
        end else begin
            if (pos_in_line == 2'd0) begin
                first_v = (it.text_byte == C_LOW_V || it.text_byte == C_UP_V);
                pos_in_line = 2'd1;
            end else if (pos_in_line == 2'd1) begin
                if (first_v && it.text_byte == C_SPACE) begin
                    vline = 1'b1;
                    if (vcount < COUNT_MAX) vcount = vcount + 24'd1;
                end
                pos_in_line = 2'd2;
            end else if (vline) begin
                if (it.text_byte == C_SPACE) begin
                    if (started) close_comp();
                end else begin
                    take_char(it.text_byte);
                end
            end
            if (it.end_of_file) begin
                if (vline) close_comp();
                clear_line();
            end
        end
        if (it.end_of_file) begin
            s = '0;
            s.kind = KIND_SUMMARY;
            s.vertex_count = vcount;
            s.loaded_ok = (vcount != 0);
            step_out.push_back(s);
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[k]) result_q.push_back(step_out[k]);
    endfunction

    // Driver: offers queued bytes, holds a request until it is taken
    always @(posedge i_clk) begin
        logic taken;
        taken = push && !full;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (taken) begin
                predict_byte(i_item);
                bytes_sent++;
            end
            if (!push || taken) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_item <= byte_q.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each popped result against the oldest expectation
    int  hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, o_item);
                end else begin
                    exp_r = result_q.pop_front();
                    if (o_item.kind !== exp_r.kind) begin
                        errors++;
                        $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, o_item.kind);
                    end
                    if (o_item.vertex_index !== exp_r.vertex_index) begin
                        errors++;
                        $display("%0t: vertex_index exp %0d got %0d", $time,
                                 exp_r.vertex_index, o_item.vertex_index);
                    end
                    if (o_item.component_index !== exp_r.component_index) begin
                        errors++;
                        $display("%0t: component_index exp %0d got %0d", $time,
                                 exp_r.component_index, o_item.component_index);
                    end
                    if (o_item.value !== exp_r.value) begin
                        errors++;
                        $display("%0t: value exp %h got %h", $time, exp_r.value, o_item.value);
                    end
                    if (o_item.vertex_count !== exp_r.vertex_count) begin
                        errors++;
                        $display("%0t: vertex_count exp %0d got %0d", $time,
                                 exp_r.vertex_count, o_item.vertex_count);
                    end
                    if (o_item.loaded_ok !== exp_r.loaded_ok) begin
                        errors++;
                        $display("%0t: loaded_ok exp %0d got %0d", $time,
                                 exp_r.loaded_ok, o_item.loaded_ok);
                    end
                    if (o_item.last !== exp_r.last) begin
                        errors++;
                        $display("%0t: last exp %0d got %0d", $time, exp_r.last, o_item.last);
                    end
                end
            end
            // long receiver hold-off, counted here
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] b, logic eof = 1'b0);
        t_in_item it;
        it.text_byte = b;
        it.end_of_file = eof;
        byte_q.push_back(it);
    endtask

    task automatic add_text(string s, logic eof_last = 1'b0);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k], eof_last && (k == s.len() - 1));
    endtask

    // Random number text, occasionally malformed
    task automatic add_number();
        int nint, nfrac;
        if ($urandom_range(99) < 30) add_byte(C_MINUS);
        nint = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(1, 5);
        for (int k = 0; k < nint; k++) begin
            if ($urandom_range(49) == 0) add_byte(8'($urandom_range(255)));
            else add_byte(8'(C_ZERO + $urandom_range(9)));
            if ($urandom_range(99) == 0) add_byte(C_MINUS);
        end
        if ($urandom_range(1)) begin
            add_byte(C_POINT);
            nfrac = ($urandom_range(5) == 0) ? $urandom_range(13) : $urandom_range(1, 6);
            for (int k = 0; k < nfrac; k++) add_byte(8'(C_ZERO + $urandom_range(9)));
        end
    endtask

    // One random file; the final byte carries end of file
    task automatic add_file();
        int nlines, ncomp, sel;
        nlines = $urandom_range(1, 6);
        for (int l = 0; l < nlines; l++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                add_byte($urandom_range(1) ? C_LOW_V : C_UP_V);
                add_byte(C_SPACE);
                ncomp = $urandom_range(5);
                for (int c = 0; c < ncomp; c++) begin
                    repeat ($urandom_range(1, 2)) add_byte(C_SPACE);
                    add_number();
                end
                if ($urandom_range(9) == 0) add_byte(C_SPACE);
            end else if (sel < 78) begin
                // empty line
            end else if (sel < 84) begin
                add_byte($urandom_range(1) ? C_LOW_V : 8'h66);
            end else if (sel < 90) begin
                add_text("vt 0.5 0.5");
            end else begin
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
            end
            if (l < nlines - 1 || $urandom_range(1)) add_byte(C_NEWLINE);
        end
        if (byte_q.size() > 0) byte_q[byte_q.size() - 1].end_of_file = 1'b1;
    endtask

    task automatic drain();
        while (byte_q.size() > 0 || push || result_q.size() > 0) @(negedge i_clk);
    endtask

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        idle_tab  = '{0, 85, 0, 27};
        stall_tab = '{0, 0, 85, 27};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, special cases
        add_text("v 0 1 -1\n");
        add_text("V -1.5 2.25 3.999999999999\n");
        add_text("\n");
        add_text("v\n");
        add_text("v \n");
        add_text("v 1 2 3 4 5\n");
        add_text("v  32767.99999 -32768 99999999999\n");
        add_text("v 1-2 .5 -.\n");
        add_text("x 1 2 3\n");
        add_text("v 7 8", 1'b1);
        add_text("v 4\n", 1'b1);
        add_byte(8'hFF);
        add_byte(8'h00, 1'b1);
        drain();

        // Random phases with varying pressure on both sides
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            if (ph == 0) hold_req = 1'b1;
            while (byte_q.size() < PHASE_BYTES) add_file();
            drain();
        end
        repeat (200) @(negedge i_clk);

        $display("Sent %0d bytes, checked %0d results, %0d vertices in the last count.",
                 bytes_sent, results_seen, vcount);
        $display("Phases ran without idling, with sender gaps, receiver stalls and both.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
